>>> rtl/hashed_value_noise_2d_top_macros.svh
// assertion macros for the hashed value noise block
`ifndef HASHED_VALUE_NOISE_2D_TOP_MACROS_SVH
`define HASHED_VALUE_NOISE_2D_TOP_MACROS_SVH

`ifndef SYNTHESIS
// check a property on a given clock, held off while reset is low
`define HVN_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on clk_i, held off while rst_ni is low
`define HVN_ASSERT(lbl, prop, msg) \
  `HVN_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define HVN_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define HVN_ASSERT(lbl, prop, msg)
`endif

`endif

>>> rtl/hvn2d_pkg.sv
// shared constants, types and helper functions of the value noise block
package hvn2d_pkg;

  // coordinate format
  localparam int unsigned CoordW        = 32;
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned WeightW       = 16;
  localparam int unsigned ValueW        = 24;
  localparam int unsigned FracUp = (CoordFracBits < WeightW) ? WeightW - CoordFracBits : 0;
  localparam int unsigned FracDn = (CoordFracBits > WeightW) ? CoordFracBits - WeightW : 0;

  // pipeline depth, input register to output register
  localparam int unsigned NumStages = 8;

  // hash constants
  localparam logic [31:0] HashAdd    = 32'h9E37_79B9;
  localparam logic [31:0] HashMulX   = 32'h85EB_CA6B;
  localparam logic [31:0] HashMulY   = 32'hC2B2_AE35;
  localparam logic [31:0] HashMulFin = 32'h7FEB_352D;

  // blend constants
  localparam logic [16:0] WeightOne = 17'd65536;
  localparam logic [17:0] ThreeQ16  = 18'd196608;

  // configuration
  localparam int unsigned PaddrW    = 3;
  localparam logic        RegNoiseSeed = 1'b0;
  localparam logic [31:0] SeedReset = 32'd1;

  typedef logic [CoordW-1:0]  coord_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [ValueW-1:0]  value_t;

  // lattice cell: arithmetic shift right (floor)
  function automatic coord_t floor_cell(input coord_t c);
    floor_cell = coord_t'($signed(c) >>> CoordFracBits);
  endfunction

  // fraction brought to q0.16
  function automatic weight_t frac_q16(input coord_t c);
    coord_t m;
    m = c & ((coord_t'(1) << CoordFracBits) - coord_t'(1));
    frac_q16 = weight_t'((m << FracUp) >> FracDn);
  endfunction

endpackage

>>> rtl/hvn2d_stream_if.sv
// valid/ready channel interfaces for coordinates and noise values
interface hvn2d_coord_if
  import hvn2d_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

interface hvn2d_noise_if
  import hvn2d_pkg::*;
;
  logic   valid;
  logic   ready;
  value_t noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

>>> rtl/hashed_value_noise_2d_top.sv
// top level of the seeded 2d value noise block
// usage:
//  - coord_i carries one sample point per transaction: coord_x and coord_y in
//    two's complement fixed point with 16 fraction bits
//  - noise_o carries one noise_value per transaction, 0..16777215 for 0..1.0
//  - noise_seed sits at APB byte address 0; write it while no transaction is
//    in flight; reads return the current seed, pready is always high
// timing:
//  - eight register stages; one transaction per cycle is sustained while the
//    receiver does not stall, set by the pipeline of hash, smoothstep and
//    blend multipliers (at most one multiply per stage)
//  - the last stage is the output register; when the receiver stalls with it
//    full, the whole pipeline holds, bubbles included, and coord_i.ready
//    drops; nothing is lost or repeated
// reset:
//  - reset clears all valid bits and sets the seed to 1; no clearing pass
`include "hashed_value_noise_2d_top_macros.svh"
module hashed_value_noise_2d_top
  import hvn2d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  hvn2d_coord_if.sink       coord_i,
  hvn2d_noise_if.source     noise_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic                 pipe_en;
  logic [NumStages-1:0] valid_q;
  coord_t               seed_q;
  logic                 cfg_wr;

  // stage 1: cells and fractions
  coord_t  x0_q, x1_q, y0_q, y1_q;
  weight_t fx_q, fy_q;
  // stage 2: squared fractions and 3-2f
  logic [31:0] f2x_q, f2y_q;
  logic [17:0] tx_q, ty_q;
  // stage 3 and 4: smoothstep weights
  weight_t ux3_q, uy3_q, ux4_q, uy4_q;
  logic [49:0] smx, smy;
  // corner values from the hash units
  value_t corner_a, corner_b, corner_c, corner_d;
  // stage 5: row blend products
  logic [40:0] a_lo_q, b_hi_q, c_lo_q, d_hi_q;
  weight_t uy5_q, uy6_q;
  logic [41:0] top_sum, bot_sum;
  // stage 6: row results
  value_t top_q, bot_q;
  // stage 7: column blend products
  logic [40:0] t_lo_q, b2_hi_q;
  logic [41:0] col_sum;
  // stage 8: output register
  value_t noise_q;

  // pipeline advances unless the output register is full and stalled
  assign pipe_en       = !valid_q[NumStages-1] || noise_o.ready;
  assign coord_i.ready = pipe_en;
  assign noise_o.valid = valid_q[NumStages-1];
  assign noise_o.noise_value = noise_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pipe_en) begin
      valid_q <= {valid_q[NumStages-2:0], coord_i.valid};
    end
  end

  // apb register
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegNoiseSeed);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegNoiseSeed) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (cfg_wr) begin
      seed_q <= pwdata;
    end
  end

  // smoothstep products
  assign smx = 50'(f2x_q) * 50'(tx_q);
  assign smy = 50'(f2y_q) * 50'(ty_q);

  // blend sums
  assign top_sum = 42'(a_lo_q) + 42'(b_hi_q);
  assign bot_sum = 42'(c_lo_q) + 42'(d_hi_q);
  assign col_sum = 42'(t_lo_q) + 42'(b2_hi_q);

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // stage 1
      x0_q <= floor_cell(coord_i.coord_x);
      x1_q <= floor_cell(coord_i.coord_x) + coord_t'(1);
      y0_q <= floor_cell(coord_i.coord_y);
      y1_q <= floor_cell(coord_i.coord_y) + coord_t'(1);
      fx_q <= frac_q16(coord_i.coord_x);
      fy_q <= frac_q16(coord_i.coord_y);
      // stage 2
      f2x_q <= 32'(fx_q) * 32'(fx_q);
      f2y_q <= 32'(fy_q) * 32'(fy_q);
      tx_q  <= ThreeQ16 - {1'b0, fx_q, 1'b0};
      ty_q  <= ThreeQ16 - {1'b0, fy_q, 1'b0};
      // stage 3
      ux3_q <= smx[47:32];
      uy3_q <= smy[47:32];
      // stage 4
      ux4_q <= ux3_q;
      uy4_q <= uy3_q;
      // stage 5
      a_lo_q <= 41'(corner_a) * 41'(WeightOne - 17'(ux4_q));
      b_hi_q <= 41'(corner_b) * 41'(ux4_q);
      c_lo_q <= 41'(corner_c) * 41'(WeightOne - 17'(ux4_q));
      d_hi_q <= 41'(corner_d) * 41'(ux4_q);
      uy5_q  <= uy4_q;
      // stage 6
      top_q <= top_sum[39:16];
      bot_q <= bot_sum[39:16];
      uy6_q <= uy5_q;
      // stage 7
      t_lo_q  <= 41'(top_q) * 41'(WeightOne - 17'(uy6_q));
      b2_hi_q <= 41'(bot_q) * 41'(uy6_q);
      // stage 8
      noise_q <= col_sum[39:16];
    end
  end

  // corner hashes, stages 2 to 4
  hvn2d_hash u_hash_a (
    .clk_i, .en_i(pipe_en), .seed_i(seed_q), .x_i(x0_q), .y_i(y0_q), .value_o(corner_a)
  );
  hvn2d_hash u_hash_b (
    .clk_i, .en_i(pipe_en), .seed_i(seed_q), .x_i(x1_q), .y_i(y0_q), .value_o(corner_b)
  );
  hvn2d_hash u_hash_c (
    .clk_i, .en_i(pipe_en), .seed_i(seed_q), .x_i(x0_q), .y_i(y1_q), .value_o(corner_c)
  );
  hvn2d_hash u_hash_d (
    .clk_i, .en_i(pipe_en), .seed_i(seed_q), .x_i(x1_q), .y_i(y1_q), .value_o(corner_d)
  );

  // input stalls only behind a full, stalled output register
  `HVN_ASSERT(a_stall_has_output, !coord_i.ready |-> noise_o.valid, "stall without output")
  // an accepted transaction enters the first stage
  `HVN_ASSERT(a_accept_enters, coord_i.valid && coord_i.ready |=> valid_q[0], "transaction lost")
  // a seed write lands in the register
  `HVN_ASSERT(a_seed_write, cfg_wr |=> seed_q == $past(pwdata), "seed write lost")

endmodule

>>> rtl/hvn2d_hash.sv
// three-stage seeded corner hash, low 24 bits out
module hvn2d_hash
  import hvn2d_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  coord_t seed_i,
  input  coord_t x_i,
  input  coord_t y_i,
  output value_t value_o
);

  coord_t mx_q, mx_d;
  coord_t my_q, my_d;
  coord_t mix_q, mix_d;
  coord_t fin_q, fin_d;
  coord_t rot;
  coord_t hy;
  coord_t out_h;

  // stage one: coordinate multiplies
  assign mx_d = coord_t'(x_i * HashMulX);
  assign my_d = coord_t'(y_i * HashMulY);

  // stage two: seed add, rotate, xor and xor-shift
  assign rot   = {(seed_i + HashAdd ^ mx_q) << 13} | ((seed_i + HashAdd ^ mx_q) >> 19);
  assign hy    = rot ^ my_q;
  assign mix_d = hy ^ (hy >> 16);

  // stage three: finalizer multiply
  assign fin_d = coord_t'(mix_q * HashMulFin);

  // final xor-shift and mask
  assign out_h   = fin_q ^ (fin_q >> 15);
  assign value_o = out_h[ValueW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q  <= mx_d;
      my_q  <= my_d;
      mix_q <= mix_d;
      fin_q <= fin_d;
    end
  end

endmodule

>>> tb/sv/hashed_value_noise_2d_top_tb.sv
// self-checking testbench for the seeded 2d value noise block
`timescale 1ns / 100ps

module hashed_value_noise_2d_top_tb;
  import hvn2d_pkg::*;

  // register addresses and run limits
  localparam logic [PaddrW-1:0] SeedAddr  = PaddrW'(0);
  localparam logic [PaddrW-1:0] SpareAddr = PaddrW'(4);
  localparam int WatchdogLimit  = 2000;
  localparam int ItemsPerPhase  = 290;
  localparam int CornerCount    = 20;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } coord_pair_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  hvn2d_coord_if coord_if ();
  hvn2d_noise_if noise_if ();

  // seed as the block should hold it, expected noise values in order
  logic [31:0] seed_model;
  value_t      pending_noise [$];
  int          error_count;
  int          idle_cycles;
  int          sent_count;
  int          recv_count;

  hashed_value_noise_2d_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coord_i (coord_if),
    .noise_o (noise_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // edge cases: fraction extremes, cell -1 whose neighbor wraps to 0,
  // most negative and most positive coordinates, alternating bit patterns
  coord_pair_t corner_cases [CornerCount] = '{
    '{32'h0000_0000, 32'h0000_0000},
    '{32'h0000_8000, 32'h0000_8000},
    '{32'h0000_FFFF, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_FFFF},
    '{32'h0000_FFFF, 32'h0000_FFFF},
    '{32'h0000_0001, 32'h0000_0001},
    '{32'h0001_0000, 32'h0001_0000},
    '{32'hFFFF_0000, 32'hFFFF_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'hFFFF_8000, 32'h0001_8000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h8000_0000},
    '{32'h7FFF_FFFF, 32'h8000_0000},
    '{32'h8000_0000, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h0000_0000},
    '{32'h0000_0000, 32'h7FFF_FFFF},
    '{32'h7FFF_0000, 32'h8000_FFFF},
    '{32'h1234_5678, 32'h9ABC_DEF0},
    '{32'hAAAA_AAAA, 32'h5555_5555},
    '{32'h5555_5555, 32'hAAAA_AAAA}
  };

  // seeded integer hash of one lattice point
  function automatic logic [31:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                               input logic [31:0] seed);
    logic [31:0] h;
    h = seed + HashAdd;
    h = h ^ (cx * HashMulX);
    h = {h[18:0], h[31:19]};
    h = h ^ (cy * HashMulY);
    h = h ^ (h >> 16);
    h = h * HashMulFin;
    h = h ^ (h >> 15);
    return h;
  endfunction

  // coordinate fraction in q0.16
  function automatic weight_t coord_frac(input coord_t c);
    coord_t f;
    f = c & ((coord_t'(1) << CoordFracBits) - coord_t'(1));
    if (CoordFracBits >= WeightW) return weight_t'(f >> (CoordFracBits - WeightW));
    return weight_t'(f << (WeightW - CoordFracBits));
  endfunction

  // smoothstep weight f*f*(3-2f), truncated to q0.16
  function automatic weight_t fade_weight(input weight_t f);
    logic [63:0] sq;
    logic [63:0] slope;
    sq    = 64'(f) * 64'(f);
    slope = 64'd196608 - 2 * 64'(f);
    return weight_t'((sq * slope) >> 32);
  endfunction

  // linear blend of two corner values
  function automatic value_t blend(input value_t p, input value_t q, input weight_t w);
    logic [63:0] s;
    s = 64'(p) * (64'd65536 - 64'(w)) + 64'(q) * 64'(w);
    return value_t'(s >> 16);
  endfunction

  // noise value at one sample point
  function automatic value_t noise_at(input coord_t cx, input coord_t cy,
                                      input logic [31:0] seed);
    coord_t  x0;
    coord_t  y0;
    weight_t ux;
    weight_t uy;
    value_t  top;
    value_t  bot;
    x0  = coord_t'($signed(cx) >>> CoordFracBits);
    y0  = coord_t'($signed(cy) >>> CoordFracBits);
    ux  = fade_weight(coord_frac(cx));
    uy  = fade_weight(coord_frac(cy));
    top = blend(value_t'(lattice_hash(x0, y0, seed)),
                value_t'(lattice_hash(x0 + 1, y0, seed)), ux);
    bot = blend(value_t'(lattice_hash(x0, y0 + 1, seed)),
                value_t'(lattice_hash(x0 + 1, y0 + 1, seed)), ux);
    return blend(top, bot, uy);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random coordinate, weighted to cells near 0, range ends and edge fractions
  function automatic coord_t rand_coord();
    int lat_idx;
    case ($urandom_range(0, 9))
      4: begin
        lat_idx = int'($urandom_range(0, 16)) - 8;
        return (coord_t'(lat_idx) << CoordFracBits) | coord_t'($urandom_range(0, 65535));
      end
      5: begin
        if ($urandom_range(0, 1)) return 32'h7FF0_0000 | coord_t'($urandom_range(0, 20'hFFFFF));
        return 32'h8000_0000 | coord_t'($urandom_range(0, 20'hFFFFF));
      end
      6: begin
        case ($urandom_range(0, 3))
          0: return {16'($urandom), 16'h0000};
          1: return {16'($urandom), 16'hFFFF};
          2: return {16'($urandom), 16'h0001};
          default: return {16'($urandom), 16'h8000};
        endcase
      end
      7: return coord_t'($urandom) & ~((coord_t'(1) << CoordFracBits) - coord_t'(1));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: ready in bursts with random stalls, some bursts long
  initial begin
    noise_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      int busy;
      int stall;
      busy  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      stall = pick_idle_len();
      noise_if.ready <= 1'b1;
      repeat (busy) @(posedge clk_i);
      if (stall > 0) begin
        noise_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // coordinate transactions in, noise transactions checked out
  always @(posedge clk_i) begin
    if (rst_ni && coord_if.valid && coord_if.ready) begin
      pending_noise.insert(pending_noise.size(),
                           noise_at(coord_if.coord_x, coord_if.coord_y, seed_model));
    end
    if (rst_ni && noise_if.valid && noise_if.ready) begin
      recv_count++;
      if (pending_noise.size() == 0) begin
        $error("noise_value %0d arrived with nothing expected", noise_if.noise_value);
        error_count++;
      end else begin
        if (noise_if.noise_value !== pending_noise[0]) begin
          $error("noise_value mismatch: expected %0d, actual %0d",
                 pending_noise[0], noise_if.noise_value);
          error_count++;
        end
        void'(pending_noise.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk_i) begin
    if ((coord_if.valid && coord_if.ready) || (noise_if.valid && noise_if.ready) || psel ||
        !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("hashed_value_noise_2d_top_tb: done, errors");
        $finish;
      end
    end
  end

  // register write: setup then access phase, then back to idle
  task automatic reg_write(input logic [PaddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SeedAddr) seed_model = data;
    @(posedge clk_i);
  endtask

  // read the seed back and compare
  task automatic seed_readback();
    logic [31:0] rdata;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SeedAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata !== seed_model) begin
      $error("noise_seed mismatch: expected %0h, actual %0h", seed_model, rdata);
      error_count++;
    end
    @(posedge clk_i);
  endtask

  // wait out every expected result, then let the pipeline settle
  task automatic wait_drained();
    while (recv_count != sent_count) @(posedge clk_i);
    repeat (NumStages) @(posedge clk_i);
  endtask

  // one coordinate transaction; valid stays high unless a gap or drain follows
  task automatic send_coord(input coord_t x, input coord_t y, input int gap, input bit drain);
    coord_if.valid   <= 1'b1;
    coord_if.coord_x <= x;
    coord_if.coord_y <= y;
    do @(posedge clk_i); while (!coord_if.ready);
    sent_count++;
    if (gap > 0 || drain) coord_if.valid <= 1'b0;
    if (drain) while (recv_count != sent_count) @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
  endtask

  // random phase, no sender gaps if steady; drains midway and at the end
  task automatic run_random(input int count, input bit steady);
    for (int n = 0; n < count; n++) begin
      int gap;
      gap = steady ? 0 : pick_idle_len();
      send_coord(rand_coord(), rand_coord(), gap, (n == count / 2) || (n == count - 1));
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    error_count = 0;
    idle_cycles = 0;
    sent_count  = 0;
    recv_count  = 0;
    seed_model  = SeedReset;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= SeedAddr;
    pwdata           <= 32'd0;
    coord_if.valid   <= 1'b0;
    coord_if.coord_x <= 32'd0;
    coord_if.coord_y <= 32'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed after reset, then the edge cases on it
    seed_readback();
    for (int i = 0; i < CornerCount; i++) begin
      send_coord(corner_cases[i].x, corner_cases[i].y, $urandom_range(0, 2),
                 i == CornerCount - 1);
    end
    wait_drained();

    // a write to the spare address must leave the seed alone
    reg_write(SpareAddr, $urandom);
    seed_readback();
    run_random(ItemsPerPhase, 1'b0);

    // seed extremes, the no-gap phase on all ones
    reg_write(SeedAddr, 32'h0000_0000);
    seed_readback();
    send_coord(corner_cases[0].x, corner_cases[0].y, 0, 1'b0);
    send_coord(corner_cases[11].x, corner_cases[11].y, 0, 1'b1);
    run_random(ItemsPerPhase, 1'b0);

    reg_write(SeedAddr, 32'hFFFF_FFFF);
    seed_readback();
    run_random(ItemsPerPhase, 1'b1);

    reg_write(SeedAddr, 32'h8000_0000);
    seed_readback();
    run_random(ItemsPerPhase, 1'b0);

    // random seeds
    for (int p = 0; p < 3; p++) begin
      reg_write(SeedAddr, $urandom);
      seed_readback();
      run_random(ItemsPerPhase, p == 1);
    end

    wait_drained();
    if (error_count == 0 && pending_noise.size() == 0) begin
      $display("hashed_value_noise_2d_top_tb: done, clean");
    end else begin
      $display("hashed_value_noise_2d_top_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hvn2d_pkg.sv
rtl/hvn2d_stream_if.sv
rtl/hvn2d_hash.sv
rtl/hashed_value_noise_2d_top.sv
tb/sv/hashed_value_noise_2d_top_tb.sv
